// ===== hdl/slc_pkg.sv =====
// Shared types and constants for the string literal checker.
// No dependencies; every other file in hdl/ refers to this package by scoped name.
package slc_pkg;

    // Token length limit and the saturation cap it implies on the 16-bit count
    localparam logic [31:0] LENGTH_LIMIT = 32'd65535;
    localparam logic [15:0] LENGTH_CAP   =
        (LENGTH_LIMIT > 32'd65535) ? 16'hFFFF : LENGTH_LIMIT[15:0];

    // Printable ASCII bounds
    localparam logic [7:0] PRINT_LO = 8'd32;
    localparam logic [7:0] PRINT_HI = 8'd126;

    // Hex run lengths for the x and u escapes
    localparam logic [2:0] HEX2_DIGITS = 3'd2;
    localparam logic [2:0] HEX4_DIGITS = 3'd4;

    typedef enum logic [1:0] {
        KIND_IDLE = 2'd0,
        KIND_STR  = 2'd1,
        KIND_CHR  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        PH_BODY  = 3'd0,
        PH_ESC   = 3'd1,
        PH_HEX2  = 3'd2,
        PH_HEX4  = 3'd3,
        PH_CLOSE = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        ST_PENDING      = 3'd0,
        ST_STRING_OK    = 3'd1,
        ST_CHAR_OK      = 3'd2,
        ST_BAD_ESCAPE   = 3'd3,
        ST_BAD_STR_CHAR = 3'd4,
        ST_UNTERMINATED = 3'd5,
        ST_BAD_CHAR_LIT = 3'd6,
        ST_NOT_LITERAL  = 3'd7
    } status_t;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       at_end;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        byte_consumed;
        logic [15:0] token_length;
    } out_word_t;

    // Scanner state carried from one word to the next
    typedef struct packed {
        kind_t       kind;
        phase_t      phase;
        logic [2:0]  hex_seen;
        logic [15:0] length;
    } scan_state_t;

    // Byte classification handed from the classifier to the step logic
    typedef struct packed {
        logic is_dquote;
        logic is_squote;
        logic is_bslash;
        logic is_print;
        logic is_hex;
        logic is_simple_esc;
        logic is_x;
        logic is_u;
    } byte_class_t;

endpackage

// ===== hdl/slc_classify.sv =====
// Byte classifier for the string literal checker.
// Depends on slc_pkg (byte_class_t, printable bounds).
module slc_classify (
    input  logic [7:0]          char_byte,
    output slc_pkg::byte_class_t cls
);

    logic is_digit;
    logic is_lower_hex;
    logic is_upper_hex;

    assign is_digit     = (char_byte >= 8'h30) && (char_byte <= 8'h39);
    assign is_lower_hex = (char_byte >= 8'h61) && (char_byte <= 8'h66);
    assign is_upper_hex = (char_byte >= 8'h41) && (char_byte <= 8'h46);

    always_comb begin
        cls.is_dquote     = (char_byte == 8'h22);
        cls.is_squote     = (char_byte == 8'h27);
        cls.is_bslash     = (char_byte == 8'h5C);
        cls.is_print      = (char_byte >= slc_pkg::PRINT_LO) &&
                            (char_byte <= slc_pkg::PRINT_HI);
        cls.is_hex        = is_digit || is_lower_hex || is_upper_hex;
        // quote, double quote, backslash, n, r, t, 0
        cls.is_simple_esc = (char_byte == 8'h27) || (char_byte == 8'h22) ||
                            (char_byte == 8'h5C) || (char_byte == 8'h6E) ||
                            (char_byte == 8'h72) || (char_byte == 8'h74) ||
                            (char_byte == 8'h30);
        cls.is_x          = (char_byte == 8'h78);
        cls.is_u          = (char_byte == 8'h75);
    end

endmodule

// ===== hdl/slc_step.sv =====
// Per-word scanner step: next state and result from current state and one word.
// Depends on slc_pkg (scan_state_t, byte_class_t, status and phase codes).
module slc_step (
    input  slc_pkg::scan_state_t cur,
    input  slc_pkg::byte_class_t cls,
    input  logic                 at_end,
    output slc_pkg::scan_state_t nxt,
    output slc_pkg::out_word_t   res
);

    slc_pkg::status_t status;
    logic             take;
    slc_pkg::phase_t  after_content;
    logic [2:0]       hex_inc;
    logic [2:0]       hex_target;
    logic [15:0]      len_inc;

    assign after_content = (cur.kind == slc_pkg::KIND_STR) ? slc_pkg::PH_BODY
                                                           : slc_pkg::PH_CLOSE;
    assign hex_inc    = cur.hex_seen + 3'd1;
    assign hex_target = (cur.phase == slc_pkg::PH_HEX2) ? slc_pkg::HEX2_DIGITS
                                                        : slc_pkg::HEX4_DIGITS;
    assign len_inc    = (take && (cur.length < slc_pkg::LENGTH_CAP))
                        ? cur.length + 16'd1 : cur.length;

    // Outputs: status and consume flag
    always_comb begin
        status = slc_pkg::ST_PENDING;
        take   = 1'b0;
        if (cur.kind == slc_pkg::KIND_IDLE) begin
            if (!at_end && (cls.is_dquote || cls.is_squote)) begin
                take = 1'b1;
            end else begin
                status = slc_pkg::ST_NOT_LITERAL;
            end
        end else begin
            unique case (cur.phase) inside
                slc_pkg::PH_BODY: begin
                    if (cur.kind == slc_pkg::KIND_STR) begin
                        if (at_end) begin
                            status = slc_pkg::ST_UNTERMINATED;
                        end else if (cls.is_dquote) begin
                            take   = 1'b1;
                            status = slc_pkg::ST_STRING_OK;
                        end else if (cls.is_bslash || cls.is_print) begin
                            take = 1'b1;
                        end else begin
                            status = slc_pkg::ST_BAD_STR_CHAR;
                        end
                    end else if (!at_end && (cls.is_bslash || cls.is_print)) begin
                        take = 1'b1;
                    end else begin
                        status = slc_pkg::ST_BAD_CHAR_LIT;
                    end
                end
                slc_pkg::PH_ESC: begin
                    if (!at_end && (cls.is_simple_esc || cls.is_x || cls.is_u)) begin
                        take = 1'b1;
                    end else begin
                        status = slc_pkg::ST_BAD_ESCAPE;
                    end
                end
                slc_pkg::PH_HEX2, slc_pkg::PH_HEX4: begin
                    if (!at_end && cls.is_hex) begin
                        take = 1'b1;
                    end else begin
                        status = slc_pkg::ST_BAD_ESCAPE;
                    end
                end
                slc_pkg::PH_CLOSE: begin
                    if (!at_end && cls.is_squote) begin
                        take   = 1'b1;
                        status = slc_pkg::ST_CHAR_OK;
                    end else begin
                        status = slc_pkg::ST_BAD_CHAR_LIT;
                    end
                end
                default: begin
                    status = slc_pkg::ST_BAD_ESCAPE;
                end
            endcase
        end
    end

    // Next state
    always_comb begin
        nxt        = cur;
        nxt.length = len_inc;
        if (status != slc_pkg::ST_PENDING) begin
            nxt.kind     = slc_pkg::KIND_IDLE;
            nxt.phase    = slc_pkg::PH_BODY;
            nxt.hex_seen = 3'd0;
            nxt.length   = 16'd0;
        end else if (cur.kind == slc_pkg::KIND_IDLE) begin
            nxt.kind     = cls.is_dquote ? slc_pkg::KIND_STR : slc_pkg::KIND_CHR;
            nxt.phase    = slc_pkg::PH_BODY;
            nxt.hex_seen = 3'd0;
        end else begin
            unique case (cur.phase) inside
                slc_pkg::PH_BODY: begin
                    if (cls.is_bslash) begin
                        nxt.phase = slc_pkg::PH_ESC;
                    end else if (cur.kind == slc_pkg::KIND_CHR) begin
                        nxt.phase = slc_pkg::PH_CLOSE;
                    end
                end
                slc_pkg::PH_ESC: begin
                    if (cls.is_x) begin
                        nxt.phase    = slc_pkg::PH_HEX2;
                        nxt.hex_seen = 3'd0;
                    end else if (cls.is_u) begin
                        nxt.phase    = slc_pkg::PH_HEX4;
                        nxt.hex_seen = 3'd0;
                    end else begin
                        nxt.phase = after_content;
                    end
                end
                slc_pkg::PH_HEX2, slc_pkg::PH_HEX4: begin
                    if (hex_inc >= hex_target) begin
                        nxt.phase    = after_content;
                        nxt.hex_seen = 3'd0;
                    end else begin
                        nxt.hex_seen = hex_inc;
                    end
                end
                default: begin
                    nxt.phase = cur.phase;
                end
            endcase
        end
    end

    always_comb begin
        res.status        = status;
        res.byte_consumed = take;
        res.token_length  = len_inc;
    end

endmodule

// ===== hdl/string_literal_checker_top.sv =====
// A word accepted into the input register passes through the scanner step into the
// result register, from which it is offered. Throughput: one word per cycle, set
// by the combinational scanner step between the two registers; m_ready low stalls
// both once full. Reset: synchronous, active-low aresetn empties both registers
// and returns the scanner to idle, body phase, no hex digits, length zero.
// Depends on slc_pkg, slc_classify and slc_step.
module string_literal_checker_top (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  slc_pkg::in_word_t    s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output slc_pkg::out_word_t   m_data
);

    // Input register: holds one word waiting for the scanner step
    logic                 in_valid_reg;
    slc_pkg::in_word_t    in_word_reg;

    // Result register and scanner state
    logic                 out_valid_reg;
    slc_pkg::out_word_t   out_word_reg;
    slc_pkg::scan_state_t state_reg;
    slc_pkg::scan_state_t state_next;
    slc_pkg::out_word_t   out_word_next;

    slc_pkg::byte_class_t cls;
    logic                 advance;

    // Advance the held word into the result register when that slot is free
    // or its current word leaves this cycle.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);

    // Accept a new word whenever the input register empties or moves on.
    assign s_ready = !in_valid_reg || advance;

    assign m_valid = out_valid_reg;
    assign m_data  = out_word_reg;

    slc_classify u_classify (
        .char_byte (in_word_reg.char_byte),
        .cls       (cls)
    );

    // Scanner step: classify result plus current state give next state and result
    slc_step u_step (
        .cur    (state_reg),
        .cls    (cls),
        .at_end (in_word_reg.at_end),
        .nxt    (state_next),
        .res    (out_word_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{kind:     slc_pkg::KIND_IDLE,
                               phase:    slc_pkg::PH_BODY,
                               hex_seen: 3'd0,
                               length:   16'd0};
        end else begin
            // Input side: load on accept, drop once passed on
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            // Result side: load on advance, drop when taken
            if (advance) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_word_reg <= s_data;
        end
        if (advance) begin
            out_word_reg <= out_word_next;
        end
    end

endmodule

// ===== dv/tb_string_literal_checker_top.sv =====
// Self-checking testbench for string_literal_checker_top: literal scanning with escapes,
// token length and valid/ready flow control on both channels.
// Depends on slc_pkg and the RTL under hdl/.
`timescale 1ns / 1ps

module tb_string_literal_checker_top;

    // Source bytes the scanner treats specially
    localparam logic [7:0] CH_DQ   = 8'h22;  // "
    localparam logic [7:0] CH_SQ   = 8'h27;  // '
    localparam logic [7:0] CH_BSL  = 8'h5C;  // backslash
    localparam logic [7:0] CH_N    = 8'h6E;
    localparam logic [7:0] CH_R    = 8'h72;
    localparam logic [7:0] CH_T    = 8'h74;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_X    = 8'h78;
    localparam logic [7:0] CH_U    = 8'h75;

    localparam int  HOLD_CYCLES = 300;        // long receiver hold-off
    localparam int  DRAIN_EXTRA = 10;         // settle time after the final drain
    localparam longint CYCLE_LIMIT = 1_000_000;

    // Scoreboard: tracks the scanner state on every accepted word and
    // queues the result word that the block must return for it.
    class lex_scoreboard;
        slc_pkg::kind_t      kind;
        slc_pkg::phase_t     phase;
        logic [2:0]          hex_seen;
        logic [15:0]         length;
        slc_pkg::out_word_t  expected_words[$];
        int                  errors;
        int                  words_checked;
        int                  status_hits[8];

        function new();
            clear_scan();
            errors = 0;
            words_checked = 0;
            foreach (status_hits[i]) status_hits[i] = 0;
        endfunction

        function void clear_scan();
            kind = slc_pkg::KIND_IDLE;
            phase = slc_pkg::PH_BODY;
            hex_seen = 3'd0;
            length = 16'd0;
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        function bit printable(logic [7:0] b);
            return b >= slc_pkg::PRINT_LO && b <= slc_pkg::PRINT_HI;
        endfunction

        function bit hex_digit(logic [7:0] b);
            return (b >= "0" && b <= "9") || (b >= "a" && b <= "f") ||
                   (b >= "A" && b <= "F");
        endfunction

        // Strings go back to the body after an escape, chars wait for the close.
        function slc_pkg::phase_t content_done();
            return (kind == slc_pkg::KIND_STR) ? slc_pkg::PH_BODY : slc_pkg::PH_CLOSE;
        endfunction

        // Advance the scanner on one accepted input word.
        function void note_word(slc_pkg::in_word_t w);
            slc_pkg::status_t    st;
            logic                take;
            logic [7:0]          b;
            logic                eot;
            logic [2:0]          target;
            slc_pkg::out_word_t  exp;
            st = slc_pkg::ST_PENDING;
            take = 1'b0;
            b = w.char_byte;
            eot = w.at_end;
            if (kind == slc_pkg::KIND_IDLE) begin
                if (!eot && b == CH_DQ) begin
                    kind = slc_pkg::KIND_STR;
                    take = 1'b1;
                end else if (!eot && b == CH_SQ) begin
                    kind = slc_pkg::KIND_CHR;
                    take = 1'b1;
                end else begin
                    st = slc_pkg::ST_NOT_LITERAL;
                end
                phase = slc_pkg::PH_BODY;
                hex_seen = 3'd0;
            end else begin
                case (phase) inside
                    slc_pkg::PH_BODY: begin
                        if (kind == slc_pkg::KIND_STR) begin
                            if (eot) begin
                                st = slc_pkg::ST_UNTERMINATED;
                            end else if (b == CH_DQ) begin
                                take = 1'b1;
                                st = slc_pkg::ST_STRING_OK;
                            end else if (b == CH_BSL) begin
                                take = 1'b1;
                                phase = slc_pkg::PH_ESC;
                            end else if (printable(b)) begin
                                take = 1'b1;
                            end else begin
                                st = slc_pkg::ST_BAD_STR_CHAR;
                            end
                        end else begin
                            if (!eot && b == CH_BSL) begin
                                take = 1'b1;
                                phase = slc_pkg::PH_ESC;
                            end else if (!eot && printable(b)) begin
                                take = 1'b1;
                                phase = slc_pkg::PH_CLOSE;
                            end else begin
                                st = slc_pkg::ST_BAD_CHAR_LIT;
                            end
                        end
                    end
                    slc_pkg::PH_ESC: begin
                        if (eot) begin
                            st = slc_pkg::ST_BAD_ESCAPE;
                        end else if (b == CH_SQ || b == CH_DQ || b == CH_BSL || b == CH_N ||
                                     b == CH_R || b == CH_T || b == CH_ZERO) begin
                            take = 1'b1;
                            phase = content_done();
                        end else if (b == CH_X) begin
                            take = 1'b1;
                            phase = slc_pkg::PH_HEX2;
                            hex_seen = 3'd0;
                        end else if (b == CH_U) begin
                            take = 1'b1;
                            phase = slc_pkg::PH_HEX4;
                            hex_seen = 3'd0;
                        end else begin
                            st = slc_pkg::ST_BAD_ESCAPE;
                        end
                    end
                    slc_pkg::PH_HEX2, slc_pkg::PH_HEX4: begin
                        if (!eot && hex_digit(b)) begin
                            target = (phase == slc_pkg::PH_HEX2) ? slc_pkg::HEX2_DIGITS
                                                                 : slc_pkg::HEX4_DIGITS;
                            take = 1'b1;
                            hex_seen = hex_seen + 3'd1;
                            if (hex_seen >= target) begin
                                phase = content_done();
                                hex_seen = 3'd0;
                            end
                        end else begin
                            st = slc_pkg::ST_BAD_ESCAPE;
                        end
                    end
                    slc_pkg::PH_CLOSE: begin
                        if (!eot && b == CH_SQ) begin
                            take = 1'b1;
                            st = slc_pkg::ST_CHAR_OK;
                        end else begin
                            st = slc_pkg::ST_BAD_CHAR_LIT;
                        end
                    end
                    default: st = slc_pkg::ST_BAD_ESCAPE;
                endcase
            end
            if (take && length < slc_pkg::LENGTH_CAP) length = length + 16'd1;
            exp.status = st;
            exp.byte_consumed = take;
            exp.token_length = length;
            expected_words.push_back(exp);
            if (st != slc_pkg::ST_PENDING) clear_scan();
        endfunction

        // Compare one accepted result word with the oldest prediction.
        function void check_word(slc_pkg::out_word_t got);
            slc_pkg::out_word_t exp;
            if (expected_words.size() == 0) begin
                errors++;
                $display("%0t: result word with nothing pending: status=%0d consumed=%0b len=%0d",
                         $time, got.status, got.byte_consumed, got.token_length);
                return;
            end
            exp = expected_words.pop_front();
            words_checked++;
            status_hits[exp.status]++;
            if (got.status !== exp.status) begin
                errors++;
                $display("%0t: status mismatch: expected %0d, actual %0d",
                         $time, exp.status, got.status);
            end
            if (got.byte_consumed !== exp.byte_consumed) begin
                errors++;
                $display("%0t: byte_consumed mismatch: expected %0b, actual %0b",
                         $time, exp.byte_consumed, got.byte_consumed);
            end
            if (got.token_length !== exp.token_length) begin
                errors++;
                $display("%0t: token_length mismatch: expected %0d, actual %0d",
                         $time, exp.token_length, got.token_length);
            end
        endfunction
    endclass

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    slc_pkg::in_word_t   s_data;
    logic                m_valid;
    logic                m_ready = 1'b0;
    slc_pkg::out_word_t  m_data;

    lex_scoreboard       sb;
    slc_pkg::in_word_t   src_words[$];      // words waiting to be offered
    int                  src_idle_pct = 0;  // chance per cycle that the sender idles
    int                  sink_stall_pct = 0;
    int                  hold_reqs = 0;     // bumped by the sequencer to ask for a hold-off
    int                  hold_taken = 0;
    int                  hold_left = 0;
    longint              cycle_count = 0;

    string_literal_checker_top DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // 100 MHz clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog: end the run if the block stops making progress.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still pending",
                     cycle_count, sb.pending());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Monitor both handshakes on the edge where they complete. All drivers
    // change on the same edge via nonblocking updates, so the values read
    // here are the ones the block sampled.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_word(s_data);
            if (m_valid && m_ready) sb.check_word(m_data);
        end
    end

    // Receiver: random stalls, plus a long hold-off on request. The hold-off
    // is counted here so the sender keeps offering words meanwhile.
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_taken != hold_reqs) begin
            hold_taken <= hold_reqs;
            hold_left <= HOLD_CYCLES - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // ---------------------------------------------------------------
    // Stimulus building: each helper appends words to src_words.
    // ---------------------------------------------------------------

    function automatic void push_byte(logic [7:0] b);
        slc_pkg::in_word_t w;
        w.char_byte = b;
        w.at_end = 1'b0;
        src_words.push_back(w);
    endfunction

    // End of source: the byte lane carries junk that must be ignored.
    function automatic void push_end();
        slc_pkg::in_word_t w;
        w.char_byte = 8'($urandom_range(255));
        w.at_end = 1'b1;
        src_words.push_back(w);
    endfunction

    function automatic logic [7:0] rand_hex();
        string digits = "0123456789abcdefABCDEF";
        return digits[$urandom_range(21)];
    endfunction

    // Printable byte; inside strings skip the quote and backslash, inside a
    // char literal only the backslash (a single quote is legal content).
    function automatic logic [7:0] rand_plain(bit in_char);
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(slc_pkg::PRINT_HI, slc_pkg::PRINT_LO));
        end while (b == CH_BSL || (!in_char && b == CH_DQ));
        return b;
    endfunction

    // Control byte or anything from 127 up
    function automatic logic [7:0] rand_nonprint();
        int r;
        r = $urandom_range(160);
        return (r < 32) ? 8'(r) : 8'(r + 95);
    endfunction

    function automatic bit is_escape_char(logic [7:0] b);
        return b == CH_SQ || b == CH_DQ || b == CH_BSL || b == CH_N || b == CH_R ||
               b == CH_T || b == CH_ZERO || b == CH_X || b == CH_U;
    endfunction

    function automatic bit is_hex_char(logic [7:0] b);
        return (b >= "0" && b <= "9") || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
    endfunction

    function automatic void push_escape();
        int r;
        logic [7:0] simple[7] = '{CH_SQ, CH_DQ, CH_BSL, CH_N, CH_R, CH_T, CH_ZERO};
        r = $urandom_range(99);
        push_byte(CH_BSL);
        if (r < 50) begin
            push_byte(simple[$urandom_range(6)]);
        end else if (r < 75) begin
            push_byte(CH_X);
            repeat (2) push_byte(rand_hex());
        end else begin
            push_byte(CH_U);
            repeat (4) push_byte(rand_hex());
        end
    endfunction

    // Broken escape: end after backslash, unknown escape byte, or a hex run
    // cut short by a non-hex byte or by the end.
    function automatic void push_bad_escape();
        int r;
        logic [7:0] b;
        r = $urandom_range(99);
        push_byte(CH_BSL);
        if (r < 15) begin
            push_end();
        end else if (r < 45) begin
            do b = 8'($urandom_range(255)); while (is_escape_char(b));
            push_byte(b);
        end else begin
            if ($urandom_range(1)) begin
                push_byte(CH_X);
                repeat ($urandom_range(1)) push_byte(rand_hex());
            end else begin
                push_byte(CH_U);
                repeat ($urandom_range(3)) push_byte(rand_hex());
            end
            if ($urandom_range(3) == 0) begin
                push_end();
            end else begin
                do b = 8'($urandom_range(255)); while (is_hex_char(b));
                push_byte(b);
            end
        end
    endfunction

    function automatic void build_string();
        int n;
        int r;
        n = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(8);
        push_byte(CH_DQ);
        repeat (n) begin
            if ($urandom_range(99) < 70) push_byte(rand_plain(1'b0));
            else push_escape();
        end
        r = $urandom_range(99);
        if (r < 70) push_byte(CH_DQ);
        else if (r < 78) push_end();
        else if (r < 87) push_byte(rand_nonprint());
        else push_bad_escape();
    endfunction

    function automatic void build_char();
        int r;
        logic [7:0] b;
        push_byte(CH_SQ);
        r = $urandom_range(99);
        if (r < 78) begin
            if ($urandom_range(99) < 60) push_byte(rand_plain(1'b1));
            else push_escape();
            if ($urandom_range(99) < 85) begin
                push_byte(CH_SQ);
            end else if ($urandom_range(1)) begin
                push_end();
            end else begin
                do b = 8'($urandom_range(255)); while (b == CH_SQ);
                push_byte(b);
            end
        end else if (r < 88) begin
            if ($urandom_range(1)) push_end();
            else push_byte(rand_nonprint());
        end else begin
            push_bad_escape();
        end
    endfunction

    // Noise between literals: any byte, including stray quotes, or an end.
    function automatic void build_noise();
        repeat ($urandom_range(3, 1)) begin
            if ($urandom_range(7) == 0) push_end();
            else push_byte(8'($urandom_range(255)));
        end
    endfunction

    function automatic void build_mix(int n);
        int r;
        while (src_words.size() < n) begin
            r = $urandom_range(99);
            if (r < 45) build_string();
            else if (r < 82) build_char();
            else build_noise();
        end
    endfunction

    // ---------------------------------------------------------------
    // Driving
    // ---------------------------------------------------------------

    // Offer one word; idle first at random, then hold valid and data until
    // the handshake completes.
    task automatic send_word(slc_pkg::in_word_t w);
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= w;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_all();
        while (src_words.size() != 0) send_word(src_words.pop_front());
    endtask

    // Drop valid and wait until every predicted word has come back.
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    task automatic run_phase(int idle_pct, int stall_pct, int n);
        src_idle_pct = idle_pct;
        sink_stall_pct <= stall_pct;
        build_mix(n);
        send_all();
        drain();
    endtask

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    initial begin
        sb = new();
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data <= '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed words: idle rejects, a clean string with \x, a bad string
        // byte, an unterminated string, a quote as char content, a hex run
        // cut short, a char missing its close, and an end after backslash.
        push_end();
        push_byte(8'hFF);
        push_byte(CH_DQ); push_byte(slc_pkg::PRINT_LO); push_byte(slc_pkg::PRINT_HI);
        push_byte(CH_BSL); push_byte(CH_X); push_byte("4"); push_byte("F");
        push_byte(CH_DQ);
        push_byte(CH_DQ); push_byte(8'h1F);
        push_byte(CH_DQ); push_end();
        push_byte(CH_SQ); push_byte(CH_SQ); push_byte(CH_SQ);
        push_byte(CH_SQ); push_byte(CH_BSL); push_byte(CH_U); push_byte("0");
        push_byte("g");
        push_byte(CH_SQ); push_byte("a"); push_byte("b");
        push_byte(CH_DQ); push_byte(CH_BSL); push_end();
        send_all();
        drain();

        run_phase(0, 0, 150);

        // Backpressure: hold the receiver off while the sender keeps going,
        // so the block fills and drops s_ready.
        hold_reqs <= hold_reqs + 1;
        run_phase(0, 0, 60);

        run_phase(79, 0, 180);
        run_phase(0, 79, 180);
        run_phase(6, 6, 180);

        // Let the pipeline empty; anything arriving now is unexpected.
        sink_stall_pct <= 0;
        repeat (DRAIN_EXTRA) @(posedge aclk);
        if (sb.pending() != 0) begin
            sb.errors += sb.pending();
            $display("%0t: %0d predicted words never arrived", $time, sb.pending());
        end

        $display("checked %0d result words; string ok %0d, char ok %0d, bad escape %0d,",
                 sb.words_checked, sb.status_hits[slc_pkg::ST_STRING_OK],
                 sb.status_hits[slc_pkg::ST_CHAR_OK], sb.status_hits[slc_pkg::ST_BAD_ESCAPE]);
        $display("bad string byte %0d, unterminated %0d, bad char %0d, not a literal %0d",
                 sb.status_hits[slc_pkg::ST_BAD_STR_CHAR],
                 sb.status_hits[slc_pkg::ST_UNTERMINATED],
                 sb.status_hits[slc_pkg::ST_BAD_CHAR_LIT],
                 sb.status_hits[slc_pkg::ST_NOT_LITERAL]);
        if (sb.errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
